// ----- rtl/adw_pkg.sv -----
// shared types, register codes and defaults for the audio distortion waveshaper
package adw_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int EXP_TABLE_SIZE = 256;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] MODE_SOFT = 2'd0;
  localparam logic [1:0] MODE_HARD = 2'd1;
  localparam logic [1:0] MODE_RECT = 2'd2;
  localparam logic [1:0] MODE_FUZZ = 2'd3;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;

  localparam logic [1:0]  MODE_RESET      = MODE_SOFT;
  localparam logic [14:0] THRESHOLD_RESET = 15'd16384;
  localparam logic [15:0] GAIN_RESET      = 16'd256;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] clip_threshold;
    logic [15:0] soft_gain;
  } cfg_t;

endpackage

// ----- rtl/adw_if.sv -----
// stream interfaces for the sample input and output channels
interface adw_in_if #(
  parameter int SAMPLE_BITS = adw_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_end_in;

  modport source (output valid, output sample_in, output block_end_in, input ready);
  modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface adw_out_if #(
  parameter int SAMPLE_BITS = adw_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

// ----- rtl/adw_cfg.sv -----
// apb configuration registers: mode, clip threshold and soft gain
module adw_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [adw_pkg::ADDR_W-1:0] paddr,
  input  logic [adw_pkg::DATA_W-1:0] pwdata,
  output logic [adw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output adw_pkg::cfg_t              cfg
);

  logic [1:0] reg_index;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= adw_pkg::MODE_RESET;
      cfg.clip_threshold <= adw_pkg::THRESHOLD_RESET;
      cfg.soft_gain      <= adw_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        adw_pkg::REG_MODE:      cfg.mode           <= pwdata[1:0];
        adw_pkg::REG_THRESHOLD: cfg.clip_threshold <= pwdata[14:0];
        adw_pkg::REG_GAIN:      cfg.soft_gain      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      adw_pkg::REG_MODE:      prdata = {30'd0, cfg.mode};
      adw_pkg::REG_THRESHOLD: prdata = {17'd0, cfg.clip_threshold};
      adw_pkg::REG_GAIN:      prdata = {16'd0, cfg.soft_gain};
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- rtl/adw_exp_rom.sv -----
// decaying exponential table with registered lookup of two neighboring entries
module adw_exp_rom #(
  parameter int EXP_TABLE_SIZE = adw_pkg::EXP_TABLE_SIZE,
  localparam int IW = $clog2(EXP_TABLE_SIZE + 1)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] idx,
  output logic [32:0]   e_lo,
  output logic [32:0]   e_hi
);

  typedef logic [32:0] rom_t [0:EXP_TABLE_SIZE];

  // step ratio exp(-16/size) from a taylor series in q8.56
  localparam logic [63:0] TD  = 64'(EXP_TABLE_SIZE);
  localparam logic [63:0] T0  = 64'd1 << 56;
  localparam logic [63:0] T1  = (T0 * 64'd16) / (TD * 64'd1);
  localparam logic [63:0] T2  = (T1 * 64'd16) / (TD * 64'd2);
  localparam logic [63:0] T3  = (T2 * 64'd16) / (TD * 64'd3);
  localparam logic [63:0] T4  = (T3 * 64'd16) / (TD * 64'd4);
  localparam logic [63:0] T5  = (T4 * 64'd16) / (TD * 64'd5);
  localparam logic [63:0] T6  = (T5 * 64'd16) / (TD * 64'd6);
  localparam logic [63:0] T7  = (T6 * 64'd16) / (TD * 64'd7);
  localparam logic [63:0] T8  = (T7 * 64'd16) / (TD * 64'd8);
  localparam logic [63:0] T9  = (T8 * 64'd16) / (TD * 64'd9);
  localparam logic [63:0] T10 = (T9 * 64'd16) / (TD * 64'd10);
  localparam logic [63:0] T11 = (T10 * 64'd16) / (TD * 64'd11);
  localparam logic [63:0] T12 = (T11 * 64'd16) / (TD * 64'd12);
  localparam logic [63:0] T13 = (T12 * 64'd16) / (TD * 64'd13);
  localparam logic [63:0] T14 = (T13 * 64'd16) / (TD * 64'd14);
  localparam logic [63:0] T15 = (T14 * 64'd16) / (TD * 64'd15);
  localparam logic [63:0] T16 = (T15 * 64'd16) / (TD * 64'd16);
  localparam logic [63:0] T17 = (T16 * 64'd16) / (TD * 64'd17);
  localparam logic [63:0] T18 = (T17 * 64'd16) / (TD * 64'd18);
  localparam logic [63:0] T19 = (T18 * 64'd16) / (TD * 64'd19);
  localparam logic [63:0] T20 = (T19 * 64'd16) / (TD * 64'd20);
  localparam logic [63:0] T21 = (T20 * 64'd16) / (TD * 64'd21);
  localparam logic [63:0] T22 = (T21 * 64'd16) / (TD * 64'd22);
  localparam logic [63:0] T23 = (T22 * 64'd16) / (TD * 64'd23);
  localparam logic [63:0] T24 = (T23 * 64'd16) / (TD * 64'd24);
  localparam logic [63:0] T25 = (T24 * 64'd16) / (TD * 64'd25);
  localparam logic [63:0] POS = T0 + T2 + T4 + T6 + T8 + T10 + T12 + T14 + T16 + T18
                              + T20 + T22 + T24;
  localparam logic [63:0] NEG = T1 + T3 + T5 + T7 + T9 + T11 + T13 + T15 + T17 + T19
                              + T21 + T23 + T25;
  localparam logic [63:0] R   = ((POS - NEG) + (64'd1 << 23)) >> 24;

  // entries in q1.32
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] prod;
    rom[0] = 33'h1_0000_0000;
    for (int k = 1; k <= EXP_TABLE_SIZE; k++) begin
      prod   = 64'(rom[k-1]) * R + (64'd1 << 31);
      rom[k] = 33'(prod >> 32);
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [IW-1:0] idx_next;

  assign idx_next = idx + IW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      e_lo <= ROM[idx];
      e_hi <= ROM[idx_next];
    end
  end

endmodule

// ----- rtl/audio_distortion_waveshaper.sv -----
// audio distortion waveshaper top level: seven stage shaping pipeline
// usage:
//   din carries one signed q1.15 sample and a last-of-block flag per transaction;
//   dout returns the shaped sample and the same flag, one result per transaction,
//   in order. the apb port sets mode (soft clip, hard clip, rectifier, fuzz),
//   clip threshold and soft gain; write it only while no sample is in flight.
//   pipeline: seven register stages; the stage 7 register drives dout directly.
//   throughput: one transaction per cycle while dout does not stall; the two
//   multipliers of the fuzz cube sit in separate stages, beside the gain and the
//   table-position products, the interpolation multiply has a stage of its own,
//   and the exponential table is read in a stage with no multiply.
//   every stage has a valid bit and its own ready, so bubbles close up and a stall
//   of dout backs up stage by stage; din is refused only once all stages are full.
//   a stalled result holds on dout unchanged until taken.
//   reset: all stages empty, mode soft clip, threshold 0.5, gain 1.0.
//   the exponential table is constant logic and needs no loading after reset.
module audio_distortion_waveshaper #(
  parameter int SAMPLE_BITS    = adw_pkg::SAMPLE_BITS,
  parameter int EXP_TABLE_SIZE = adw_pkg::EXP_TABLE_SIZE
) (
  input  logic                       clk,
  input  logic                       rst,
  adw_in_if.sink                     din,
  adw_out_if.source                  dout,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [adw_pkg::ADDR_W-1:0] paddr,
  input  logic [adw_pkg::DATA_W-1:0] pwdata,
  output logic [adw_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = SB - 1;
  localparam int AW  = SB + 16;
  localparam int CL  = $clog2(EXP_TABLE_SIZE + 1);
  localparam int PW  = AW + CL;
  localparam int XW  = PW - F - 12;
  localparam int MW  = 2 * SB;
  localparam int THR_SHL = (F >= 15) ? F - 15 : 0;
  localparam int THR_SHR = (F >= 15) ? 0 : 15 - F;
  localparam logic [SB-1:0] ONE_Q   = SB'(1) << F;
  localparam logic [SB-1:0] MAX_MAG = ONE_Q - SB'(1);
  localparam logic [MW-1:0] HALF    = MW'(1) << (F - 1);

  adw_pkg::cfg_t cfg;

  adw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [7:1] v;
  logic [8:1] rdy;

  always_comb begin
    rdy[8] = dout.ready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign din.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= din.valid;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: sign and magnitude
  logic [SB-1:0] raw;
  logic          s1_neg;
  logic          s1_be;
  logic [SB-1:0] s1_ax;

  assign raw = din.sample_in;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_neg <= raw[SB-1];
      s1_be  <= din.block_end_in;
      s1_ax  <= raw[SB-1] ? (SB'(0) - raw) : raw;
    end
  end

  // stage 2: gain product, hard clip and rectifier, fuzz square
  logic [SB+14:0] thr_w;
  logic [SB-1:0]  thr_q;
  logic [SB-1:0]  m1;
  logic [SB-1:0]  simple_mag;
  logic           s2_rneg;
  logic           s2_be;
  logic [AW-1:0]  s2_a;
  logic [SB-1:0]  s2_m;
  logic [MW-1:0]  s2_mm;
  logic [SB-1:0]  s2_pmag;

  always_comb begin
    thr_w = ((SB+15)'(cfg.clip_threshold) << THR_SHL) >> THR_SHR;
    thr_q = thr_w[SB-1:0];
    m1    = ONE_Q - s1_ax;
    if (cfg.mode == adw_pkg::MODE_HARD) begin
      simple_mag = (s1_ax > thr_q) ? thr_q : s1_ax;
    end else begin
      simple_mag = (s1_ax > MAX_MAG) ? MAX_MAG : s1_ax;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_rneg <= s1_neg && (cfg.mode != adw_pkg::MODE_RECT);
      s2_be   <= s1_be;
      s2_a    <= AW'(cfg.soft_gain) * AW'(s1_ax);
      s2_m    <= m1;
      s2_mm   <= MW'(m1) * MW'(m1);
      s2_pmag <= simple_mag;
    end
  end

  // stage 3: table position, fuzz cube
  logic [MW-1:0] c2_w;
  logic [SB-1:0] c2;
  logic          s3_rneg;
  logic          s3_be;
  logic [PW-1:0] s3_p;
  logic [MW-1:0] s3_c2m;
  logic [SB-1:0] s3_pmag;

  always_comb begin
    c2_w = (s2_mm + HALF) >> F;
    c2   = c2_w[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_rneg <= s2_rneg;
      s3_be   <= s2_be;
      s3_p    <= PW'(s2_a) * PW'(EXP_TABLE_SIZE);
      s3_c2m  <= MW'(c2) * MW'(s2_m);
      s3_pmag <= s2_pmag;
    end
  end

  // stage 4: table lookup, fuzz magnitude
  logic [XW-1:0] idx_full;
  logic          ovf;
  logic [CL-1:0] idx;
  logic [MW-1:0] c3_w;
  logic [SB-1:0] fmag;
  logic [32:0]   e_lo;
  logic [32:0]   e_hi;
  logic          s4_rneg;
  logic          s4_be;
  logic          s4_ovf;
  logic [15:0]   s4_f;
  logic [SB-1:0] s4_pmag;

  always_comb begin
    idx_full = s3_p[PW-1:F+12];
    ovf      = idx_full >= XW'(EXP_TABLE_SIZE);
    idx      = ovf ? '0 : idx_full[CL-1:0];
    c3_w     = (s3_c2m + HALF) >> F;
    fmag     = ONE_Q - c3_w[SB-1:0];
    if (!s3_rneg && (fmag > MAX_MAG)) begin
      fmag = MAX_MAG;
    end
  end

  adw_exp_rom #(
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_exp_rom (
    .clk  (clk),
    .en   (rdy[4]),
    .idx  (idx),
    .e_lo (e_lo),
    .e_hi (e_hi)
  );

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_rneg <= s3_rneg;
      s4_be   <= s3_be;
      s4_ovf  <= ovf;
      s4_f    <= s3_p[F+11:F-4];
      s4_pmag <= (cfg.mode == adw_pkg::MODE_FUZZ) ? fmag : s3_pmag;
    end
  end

  // stage 5: interpolation product
  logic [32:0]   d;
  logic          s5_rneg;
  logic          s5_be;
  logic          s5_ovf;
  logic [32:0]   s5_e0;
  logic [48:0]   s5_dmul;
  logic [SB-1:0] s5_pmag;

  assign d = e_lo - e_hi;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_rneg <= s4_rneg;
      s5_be   <= s4_be;
      s5_ovf  <= s4_ovf;
      s5_e0   <= e_lo;
      s5_dmul <= 49'(d) * 49'(s4_f);
      s5_pmag <= s4_pmag;
    end
  end

  // stage 6: soft clip magnitude and mode select
  logic [48:0]   dr;
  logic [32:0]   e;
  logic [33:0]   q;
  logic [33:0]   sm;
  logic [SB-1:0] smag;
  logic          s6_rneg;
  logic          s6_be;
  logic [SB-1:0] s6_mag;

  always_comb begin
    dr   = (s5_dmul + 49'd32768) >> 16;
    e    = s5_ovf ? 33'd0 : (s5_e0 - dr[32:0]);
    q    = (34'd1 << 32) - 34'(e) + (34'd1 << (31 - F));
    sm   = q >> (32 - F);
    smag = (sm > 34'(MAX_MAG)) ? MAX_MAG : sm[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_rneg <= s5_rneg;
      s6_be   <= s5_be;
      s6_mag  <= (cfg.mode == adw_pkg::MODE_SOFT) ? smag : s5_pmag;
    end
  end

  // stage 7: sign and output register
  logic [SB-1:0] s7_sample;
  logic          s7_be;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_sample <= s6_rneg ? (SB'(0) - s6_mag) : s6_mag;
      s7_be     <= s6_be;
    end
  end

  assign dout.valid         = v[7];
  assign dout.sample_out    = s7_sample;
  assign dout.block_end_out = s7_be;

endmodule

// ----- tb/tb_audio_distortion_waveshaper.sv -----
`timescale 1ns / 100ps
// testbench for the audio distortion waveshaper: corner and random samples checked bit-exact

class waveshape_scoreboard;
  typedef struct packed {
    logic [adw_pkg::SAMPLE_BITS-1:0] sample;
    logic                            block_end;
  } shaped_t;

  localparam int FRAC = adw_pkg::SAMPLE_BITS - 1;
  localparam bit [63:0] ONE_Q = 64'd1 << FRAC;
  localparam bit [63:0] HALF_Q = ONE_Q >> 1;
  localparam bit [63:0] MAX_MAG = ONE_Q - 1;

  bit [63:0]   exp_rom [adw_pkg::EXP_TABLE_SIZE+1];
  logic [1:0]  mode_q;
  logic [14:0] thr_q;
  logic [15:0] gain_q;
  shaped_t     pending_shapes [$];
  int          mismatches;
  int          checked;

  function new();
    bit [63:0] term, pos, neg, r;
    term = 64'd1 << 56;
    pos = term;
    neg = 0;
    for (int n = 1; n <= 25; n++) begin
      term = (term * 64'd16) / (64'(adw_pkg::EXP_TABLE_SIZE) * 64'(n));
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    r = (pos - neg + (64'd1 << 23)) >> 24;
    exp_rom[0] = 64'd1 << 32;
    for (int k = 1; k <= adw_pkg::EXP_TABLE_SIZE; k++)
      exp_rom[k] = (exp_rom[k-1] * r + (64'd1 << 31)) >> 32;
    mode_q = adw_pkg::MODE_RESET;
    thr_q = adw_pkg::THRESHOLD_RESET;
    gain_q = adw_pkg::GAIN_RESET;
    mismatches = 0;
    checked = 0;
  endfunction

  function void note_config(logic [1:0] idx, logic [adw_pkg::DATA_W-1:0] value);
    case (idx)
      adw_pkg::REG_MODE: mode_q = value[1:0];
      adw_pkg::REG_THRESHOLD: thr_q = value[14:0];
      adw_pkg::REG_GAIN: gain_q = value[15:0];
      default: ;
    endcase
  endfunction

  function shaped_t shape_sample(logic [adw_pkg::SAMPLE_BITS-1:0] raw, logic block_end);
    bit [63:0] ax, mag, p, idx, f, d, e, m, c2, c3, signed_mag;
    bit neg_in, neg_out;
    shaped_t res;
    neg_in = raw[adw_pkg::SAMPLE_BITS-1];
    neg_out = neg_in;
    ax = neg_in ? (ONE_Q << 1) - 64'(raw) : 64'(raw);
    case (mode_q)
      adw_pkg::MODE_SOFT: begin
        // interpolated exp(-|g*x|) from the table, then 1 - e
        p = 64'(gain_q) * ax * 64'(adw_pkg::EXP_TABLE_SIZE);
        idx = p >> (FRAC + 12);
        f = (p & ((64'd1 << (FRAC + 12)) - 1)) >> (FRAC - 4);
        if (idx >= 64'(adw_pkg::EXP_TABLE_SIZE)) begin
          e = 0;
        end else begin
          d = exp_rom[idx] - exp_rom[idx + 1];
          e = exp_rom[idx] - ((d * f + 64'd32768) >> 16);
        end
        mag = ((64'd1 << 32) - e + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
        if (mag > MAX_MAG) mag = MAX_MAG;
      end
      adw_pkg::MODE_HARD: begin
        mag = (ax > 64'(thr_q)) ? 64'(thr_q) : ax;
      end
      adw_pkg::MODE_RECT: begin
        mag = (ax > MAX_MAG) ? MAX_MAG : ax;
        neg_out = 1'b0;
      end
      adw_pkg::MODE_FUZZ: begin
        m = ONE_Q - ax;
        c2 = (m * m + HALF_Q) >> FRAC;
        c3 = (c2 * m + HALF_Q) >> FRAC;
        mag = ONE_Q - c3;
        if (!neg_in && mag > MAX_MAG) mag = MAX_MAG;
      end
      default: mag = 64'd0;
    endcase
    signed_mag = neg_out ? (64'd0 - mag) : mag;
    res.sample = signed_mag[adw_pkg::SAMPLE_BITS-1:0];
    res.block_end = block_end;
    return res;
  endfunction

  function void note_sample(logic [adw_pkg::SAMPLE_BITS-1:0] raw, logic block_end);
    pending_shapes.push_back(shape_sample(raw, block_end));
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task check_output(logic [adw_pkg::SAMPLE_BITS-1:0] sample, logic block_end);
    shaped_t want;
    if (pending_shapes.size() == 0) begin
      report($sformatf("result %h with no sample pending", sample));
      return;
    end
    want = pending_shapes.pop_front();
    checked++;
    if (sample !== want.sample)
      report($sformatf("result %0d: sample_out %h, want %h", checked, sample, want.sample));
    if (block_end !== want.block_end)
      report($sformatf("result %0d: block_end_out %b, want %b", checked, block_end,
                       want.block_end));
  endtask
endclass

module tb_audio_distortion_waveshaper;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 114;
  localparam int PIPE_DEPTH = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [adw_pkg::ADDR_W-1:0] paddr;
  logic [adw_pkg::DATA_W-1:0] pwdata;
  logic [adw_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  adw_in_if  in_ch ();
  adw_out_if out_ch ();

  waveshape_scoreboard sb;

  bit gaps_on = 1'b1;
  int hold_left = 0;
  int quiet_cycles = 0;
  int samples_sent = 0;
  int settings = 1;

  logic [adw_pkg::SAMPLE_BITS-1:0] corner_vals [6] = '{16'h0000, 16'h7FFF, 16'h8000,
                                                       16'h0001, 16'hFFFF, 16'h5555};
  logic [1:0] mode_order [4] = '{adw_pkg::MODE_SOFT, adw_pkg::MODE_HARD, adw_pkg::MODE_RECT,
                                 adw_pkg::MODE_FUZZ};

  audio_distortion_waveshaper dut (
    .clk     (clk),
    .rst     (rst),
    .din     (in_ch),
    .dout    (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [adw_pkg::SAMPLE_BITS-1:0] pick_sample();
    int unsigned sel;
    logic [adw_pkg::SAMPLE_BITS-1:0] mag;
    sel = $urandom_range(99);
    if (sel < 70) return adw_pkg::SAMPLE_BITS'($urandom);
    if (sel < 85)
      return corner_vals[$urandom_range(5)] + adw_pkg::SAMPLE_BITS'($urandom_range(2))
             - adw_pkg::SAMPLE_BITS'(1);
    mag = adw_pkg::SAMPLE_BITS'($urandom_range(600));
    return ($urandom_range(1) == 1) ? mag : -mag;
  endfunction

  task automatic push_sample(input logic [adw_pkg::SAMPLE_BITS-1:0] s, input logic be);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    in_ch.block_end_in <= be;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s, be);
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending_shapes.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [adw_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    sb.note_config(idx, value);
  endtask

  // output side: random stalls plus the long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_output(out_ch.sample_out, out_ch.block_end_out);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0]  md;
    logic [14:0] th;
    logic [15:0] gn;
    int          q;
    sb = new();
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.sample_in <= '0;
    in_ch.block_end_in <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (mode_order[mi]) begin
      if (mi != 0) begin
        wait_idle();
        apb_write(adw_pkg::REG_MODE, {30'($urandom), mode_order[mi]});
        settings++;
      end
      foreach (corner_vals[k]) push_sample(corner_vals[k], k[0]);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      q = p / 4;
      md = mode_order[p % 4];
      th = (q == 0) ? 15'd0 : (q == 1) ? 15'd32767 : (q == 2) ? 15'd1
         : 15'($urandom_range(1, 32766));
      gn = (q == 0) ? 16'd0 : (q == 1) ? 16'd65535 : (q == 2) ? 16'd1
         : 16'($urandom_range(1, 4095));
      apb_write(adw_pkg::REG_MODE, {30'($urandom), md});
      apb_write(adw_pkg::REG_THRESHOLD, {17'($urandom), th});
      apb_write(adw_pkg::REG_GAIN, {16'($urandom), gn});
      if (p == 0) apb_write(REG_SPARE, $urandom);
      settings++;
      gaps_on = (p != 2);
      if (p == 1) hold_left = HOLD_CYCLES;
      repeat (PHASE_ITEMS) push_sample(pick_sample(), $urandom_range(3) == 0);
    end

    wait_idle();
    $display("shaped %0d samples (%0d checked) over %0d register settings in all four modes",
             samples_sent, sb.checked, settings);
    $display("included zero and full-scale gain and threshold, a long output stall");
    $display("and a gap-free run");
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
